### rtl/uctl_pkg.sv
// Shared types and constants for the USB control transfer sequencer.
`default_nettype none

package uctl_pkg;

  // Largest data stage the transfer buffer holds, in bytes.
  localparam int unsigned TRANSFER_SIZE = 1024;

  localparam int unsigned CFG_W = 3;
  localparam logic [CFG_W-1:0] MPS_LOG2_MIN = 3'd3;
  localparam logic [CFG_W-1:0] MPS_LOG2_MAX = 3'd6;
  localparam logic [CFG_W-1:0] MPS_LOG2_RESET = 3'd6;

  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_TYPE_STD_DEV_OUT = 8'h00;
  localparam int unsigned DIR_BIT = 7;

  typedef enum logic [1:0] {
    CMD_BUS_RESET = 2'd0,
    CMD_SETUP     = 2'd1,
    CMD_OUT       = 2'd2,
    CMD_IN_DONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SEND   = 2'd1,
    ACT_ACCEPT = 2'd2,
    ACT_STALL  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_DATA_IN    = 3'd2,
    ST_LAST_IN    = 3'd3,
    ST_STATUS_IN  = 3'd4,
    ST_DATA_OUT   = 3'd5,
    ST_LAST_OUT   = 3'd6,
    ST_STATUS_OUT = 3'd7
  } stage_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic        setup_ok;
    logic        handled;
    logic [15:0] reply_length;
    logic        wants_completion;
    logic [9:0]  out_count;
  } in_beat_t;

endpackage

`default_nettype wire

### rtl/usb_control_transfer_sequencer.sv
// Endpoint-zero control transfer sequencer: input register, stage logic, result register.
`default_nettype none

// Each event beat is held in the input register, then its result is held in the
// result register until taken.
// Throughput: one event per cycle while the result side is not stalled; all stage
// logic is one pass between the two registers, so state is ready for the next beat.
// Reset (rst, synchronous): stage idle, counters and saved request cleared,
// device address 0, max packet log2 back to 6, both registers empty.
module usb_control_transfer_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_write_data,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_length,
  input  logic        setup_ok,
  input  logic        handled,
  input  logic [15:0] reply_length,
  input  logic        wants_completion,
  input  logic [9:0]  out_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [15:0] data_offset,
  output logic [6:0]  data_length,
  output logic [2:0]  stage,
  output logic [6:0]  device_address,
  output logic        complete_pulse
);
  import uctl_pkg::*;

  // ---------------------------------------------------------------------
  // Handshake: the input register refills whenever the result register
  // can take what it holds; a waiting result blocks intake only once the
  // input register also holds a beat.
  // ---------------------------------------------------------------------
  logic     ireg_valid;
  in_beat_t ireg;
  logic     out_free;
  logic     fire;

  assign out_free = !out_valid || out_ready;
  assign fire     = ireg_valid && out_free;
  assign in_ready = !ireg_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg <= '{cmd: cmd, request_type: request_type, request_code: request_code,
                request_value: request_value, request_length: request_length,
                setup_ok: setup_ok, handled: handled, reply_length: reply_length,
                wants_completion: wants_completion, out_count: out_count};
    end
  end

  // Max packet size register; to be written by the user only while the block is quiet; the block does not enforce it.
  logic [2:0] max_packet_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_log2 <= MPS_LOG2_RESET;
    end else if (cfg_write_en) begin
      max_packet_log2 <= cfg_write_data;
    end
  end

  // ---------------------------------------------------------------------
  // Transfer state
  // ---------------------------------------------------------------------
  stage_t      stage_reg, stage_next;
  logic [15:0] remaining_count, remaining_count_next;
  logic [15:0] buffer_offset, buffer_offset_next;
  logic        zlp_pending, zlp_pending_next;
  logic [7:0]  saved_type, saved_type_next;
  logic [7:0]  saved_code, saved_code_next;
  logic [15:0] saved_value, saved_value_next;
  logic        completion_armed, completion_armed_next;
  logic [6:0]  address_reg, address_reg_next;

  // Packet size, clamped to 8..64 bytes.
  logic [2:0]  mps_log2;
  logic [6:0]  mps;
  logic [15:0] mps16;

  assign mps_log2 = (max_packet_log2 < MPS_LOG2_MIN) ? MPS_LOG2_MIN :
                    (max_packet_log2 > MPS_LOG2_MAX) ? MPS_LOG2_MAX : max_packet_log2;
  assign mps      = 7'd1 << mps_log2;
  assign mps16    = {9'd0, mps};

  // Setup decode: reply length limited to the buffer, then to the request.
  logic        setup_in_dir;
  logic [15:0] reply_ts;
  logic [15:0] reply_len;
  logic        setup_zlp;
  logic        setup_too_long;

  assign setup_in_dir   = (ireg.request_length == 16'd0) || ireg.request_type[DIR_BIT];
  assign reply_ts       = (ireg.reply_length > 16'(TRANSFER_SIZE)) ?
                          16'(TRANSFER_SIZE) : ireg.reply_length;
  assign reply_len      = (reply_ts > ireg.request_length) ? ireg.request_length : reply_ts;
  // Short reply that ends on a packet boundary needs a zero-length packet.
  assign setup_zlp      = (reply_len < ireg.request_length) && (reply_len != 16'd0) &&
                          ((reply_len & (mps16 - 16'd1)) == 16'd0);
  assign setup_too_long = ireg.request_length > 16'(TRANSFER_SIZE);

  // Send chunk: shared by the first IN packet of a setup and later IN acks.
  logic        sc_from_setup;
  logic [15:0] sc_rem;
  logic [15:0] sc_off;
  logic        sc_zlp;
  logic        sc_full;
  logic [6:0]  sc_len;
  logic [15:0] sc_rem_next;
  logic [15:0] sc_off_next;
  logic        sc_zlp_next;
  stage_t      sc_stage;

  assign sc_from_setup = (ireg.cmd == CMD_SETUP);
  assign sc_rem      = sc_from_setup ? reply_len : remaining_count;
  assign sc_off      = sc_from_setup ? 16'd0 : buffer_offset;
  assign sc_zlp      = sc_from_setup ? setup_zlp : zlp_pending;
  assign sc_full     = sc_rem > mps16;
  assign sc_len      = sc_full ? mps : sc_rem[6:0];
  assign sc_rem_next = sc_full ? (sc_rem - mps16) : 16'd0;
  assign sc_off_next = sc_full ? (sc_off + mps16) : sc_off;
  assign sc_zlp_next = sc_full ? sc_zlp : 1'b0;
  assign sc_stage    = (sc_full || sc_zlp) ? ST_DATA_IN : ST_LAST_IN;

  // Receive chunk: expect a full packet or the remainder; extra bytes drop.
  logic [6:0]  rc_want;
  logic        rc_ok;
  logic [15:0] rc_off_next;
  logic [15:0] rc_rem_next;
  logic        rc_rem_last;

  assign rc_want     = (remaining_count < mps16) ? remaining_count[6:0] : mps;
  assign rc_ok       = ireg.out_count >= {3'd0, rc_want};
  assign rc_off_next = buffer_offset + {9'd0, rc_want};
  assign rc_rem_next = remaining_count - {9'd0, rc_want};
  assign rc_rem_last = rc_rem_next <= mps16;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    stage_next            = stage_reg;
    remaining_count_next  = remaining_count;
    buffer_offset_next    = buffer_offset;
    zlp_pending_next      = zlp_pending;
    saved_type_next       = saved_type;
    saved_code_next       = saved_code;
    saved_value_next      = saved_value;
    completion_armed_next = completion_armed;
    address_reg_next      = address_reg;
    case (ireg.cmd)
      CMD_BUS_RESET: begin
        stage_next            = ST_IDLE;
        remaining_count_next  = 16'd0;
        buffer_offset_next    = 16'd0;
        zlp_pending_next      = 1'b0;
        saved_type_next       = 8'd0;
        saved_code_next       = 8'd0;
        saved_value_next      = 16'd0;
        completion_armed_next = 1'b0;
        address_reg_next      = 7'd0;
      end
      CMD_SETUP: begin
        completion_armed_next = 1'b0;
        if (!ireg.setup_ok) begin
          stage_next = ST_IDLE;
        end else begin
          saved_type_next  = ireg.request_type;
          saved_code_next  = ireg.request_code;
          saved_value_next = ireg.request_value;
          if (setup_in_dir) begin
            buffer_offset_next = 16'd0;
            if (!ireg.handled) begin
              stage_next = ST_IDLE;
            end else begin
              completion_armed_next = ireg.wants_completion;
              if (ireg.request_length != 16'd0) begin
                zlp_pending_next     = sc_zlp_next;
                remaining_count_next = sc_rem_next;
                buffer_offset_next   = sc_off_next;
                stage_next           = sc_stage;
              end else begin
                remaining_count_next = 16'd0;
                stage_next           = ST_STATUS_IN;
              end
            end
          end else if (setup_too_long) begin
            stage_next = ST_IDLE;
          end else begin
            buffer_offset_next   = 16'd0;
            remaining_count_next = ireg.request_length;
            stage_next = (ireg.request_length > mps16) ? ST_DATA_OUT : ST_LAST_OUT;
          end
        end
      end
      CMD_OUT: begin
        case (stage_reg)
          ST_DATA_OUT, ST_LAST_OUT: begin
            if (!rc_ok) begin
              stage_next = ST_IDLE;
            end else begin
              buffer_offset_next   = rc_off_next;
              remaining_count_next = rc_rem_next;
              if (stage_reg == ST_DATA_OUT) begin
                stage_next = rc_rem_last ? ST_LAST_OUT : ST_DATA_OUT;
              end else if (ireg.handled) begin
                completion_armed_next = ireg.wants_completion;
                stage_next            = ST_STATUS_IN;
              end else begin
                stage_next = ST_IDLE;
              end
            end
          end
          ST_STATUS_OUT: begin
            stage_next            = ST_IDLE;
            completion_armed_next = 1'b0;
          end
          default: begin
            stage_next = ST_IDLE;
          end
        endcase
      end
      CMD_IN_DONE: begin
        case (stage_reg)
          ST_DATA_IN: begin
            remaining_count_next = sc_rem_next;
            buffer_offset_next   = sc_off_next;
            zlp_pending_next     = sc_zlp_next;
            stage_next           = sc_stage;
          end
          ST_LAST_IN: begin
            stage_next = ST_STATUS_OUT;
          end
          ST_STATUS_IN: begin
            completion_armed_next = 1'b0;
            // SET_ADDRESS takes effect only once its status stage is done.
            if (saved_type == REQ_TYPE_STD_DEV_OUT && saved_code == REQ_SET_ADDRESS) begin
              address_reg_next = saved_value[6:0];
            end
            stage_next = ST_IDLE;
          end
          default: begin
            stage_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        stage_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------
  action_t     res_action;
  logic [15:0] res_offset;
  logic [6:0]  res_length;
  logic        res_pulse;

  always_comb begin
    res_action = ACT_NONE;
    res_offset = 16'd0;
    res_length = 7'd0;
    res_pulse  = 1'b0;
    case (ireg.cmd)
      CMD_SETUP: begin
        if (!ireg.setup_ok) begin
          res_action = ACT_STALL;
        end else if (setup_in_dir) begin
          if (!ireg.handled) begin
            res_action = ACT_STALL;
          end else if (ireg.request_length != 16'd0) begin
            res_action = ACT_SEND;
            res_offset = sc_off;
            res_length = sc_len;
          end else begin
            // Empty status packet for a no-data request.
            res_action = ACT_SEND;
          end
        end else if (setup_too_long) begin
          res_action = ACT_STALL;
        end
      end
      CMD_OUT: begin
        case (stage_reg)
          ST_DATA_OUT, ST_LAST_OUT: begin
            if (!rc_ok || (stage_reg == ST_LAST_OUT && !ireg.handled)) begin
              res_action = ACT_STALL;
            end else begin
              res_action = ACT_ACCEPT;
              res_offset = buffer_offset;
              res_length = rc_want;
            end
          end
          ST_STATUS_OUT: begin
            res_action = ACT_ACCEPT;
            res_pulse  = completion_armed;
          end
          default: begin
            res_action = ACT_STALL;
          end
        endcase
      end
      CMD_IN_DONE: begin
        case (stage_reg)
          ST_DATA_IN: begin
            res_action = ACT_SEND;
            res_offset = sc_off;
            res_length = sc_len;
          end
          ST_LAST_IN: begin
            res_action = ACT_NONE;
          end
          ST_STATUS_IN: begin
            res_pulse = completion_armed;
          end
          default: begin
            res_action = ACT_STALL;
          end
        endcase
      end
      default: begin
        res_action = ACT_NONE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers: state advances only on a beat that moves to the result.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg        <= ST_IDLE;
      remaining_count  <= 16'd0;
      buffer_offset    <= 16'd0;
      zlp_pending      <= 1'b0;
      saved_type       <= 8'd0;
      saved_code       <= 8'd0;
      saved_value      <= 16'd0;
      completion_armed <= 1'b0;
      address_reg      <= 7'd0;
    end else if (fire) begin
      stage_reg        <= stage_next;
      remaining_count  <= remaining_count_next;
      buffer_offset    <= buffer_offset_next;
      zlp_pending      <= zlp_pending_next;
      saved_type       <= saved_type_next;
      saved_code       <= saved_code_next;
      saved_value      <= saved_value_next;
      completion_armed <= completion_armed_next;
      address_reg      <= address_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ireg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      action         <= res_action;
      data_offset    <= res_offset;
      data_length    <= res_length;
      stage          <= stage_next;
      device_address <= address_reg_next;
      complete_pulse <= res_pulse;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_STALL |-> stage == ST_IDLE)
    else $error("stall reported with a stage other than idle");

  a_pulse_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && complete_pulse |-> stage == ST_IDLE && action != ACT_STALL)
    else $error("completion pulse outside a finished status stage");

  a_len_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_length <= 7'd64)
    else $error("packet length above 64 bytes");

  a_last_in_empty: assert property (@(posedge clk) disable iff (rst)
    stage_reg == ST_LAST_IN || stage_reg == ST_STATUS_OUT |-> remaining_count == 16'd0)
    else $error("bytes left over after the last IN packet");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    ireg_valid && !out_free |=> ireg_valid && $stable(ireg))
    else $error("held event beat dropped or changed");

endmodule

`default_nettype wire

### sim/ep0_scoreboard.sv
// Scoreboard for the endpoint-zero sequencer: predicts each result beat and compares it.
`timescale 1ns / 100ps
module ep0_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_length,
  input  logic        setup_ok,
  input  logic        handled,
  input  logic [15:0] reply_length,
  input  logic        wants_completion,
  input  logic [9:0]  out_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  action,
  input  logic [15:0] data_offset,
  input  logic [6:0]  data_length,
  input  logic [2:0]  stage,
  input  logic [6:0]  device_address,
  input  logic        complete_pulse,
  output int          fail_count,
  output int          outstanding
);
  import uctl_pkg::*;

  typedef struct packed {
    action_t     act;
    logic [15:0] offset;
    logic [6:0]  len;
    logic [2:0]  stg;
    logic [6:0]  addr;
    logic        pulse;
  } ep0_result_t;

  // Mirror of the endpoint-zero state and its one register.
  logic [2:0]  mps_log2;
  stage_t      stage_q;
  logic [15:0] remain_q;
  logic [15:0] offset_q;
  logic        zlp_q;
  logic [7:0]  saved_type_q;
  logic [7:0]  saved_code_q;
  logic [15:0] saved_value_q;
  logic [15:0] saved_length_q;
  logic        armed_q;
  logic [6:0]  address_q;

  ep0_result_t nx;
  ep0_result_t expected_actions[$];
  in_beat_t    seen_beat;

  assign seen_beat = {cmd, request_type, request_code, request_value, request_length,
                      setup_ok, handled, reply_length, wants_completion, out_count};

  function automatic int unsigned packet_bytes();
    logic [2:0] l;
    l = mps_log2;
    if (l < MPS_LOG2_MIN) l = MPS_LOG2_MIN;
    if (l > MPS_LOG2_MAX) l = MPS_LOG2_MAX;
    return 32'd1 << l;
  endfunction

  task automatic clear_transfer();
    stage_q = ST_IDLE;
    remain_q = '0;
    offset_q = '0;
    zlp_q = 1'b0;
    saved_type_q = '0;
    saved_code_q = '0;
    saved_value_q = '0;
    saved_length_q = '0;
    armed_q = 1'b0;
    address_q = '0;
  endtask

  task automatic stall_transfer();
    stage_q = ST_IDLE;
    nx.act = ACT_STALL;
    nx.offset = '0;
    nx.len = '0;
  endtask

  task automatic send_chunk();
    int unsigned mps;
    mps = packet_bytes();
    nx.act = ACT_SEND;
    nx.offset = offset_q;
    if (remain_q > mps) begin
      nx.len = mps[6:0];
      stage_q = ST_DATA_IN;
      offset_q = offset_q + mps[15:0];
      remain_q = remain_q - mps[15:0];
    end else begin
      nx.len = remain_q[6:0];
      stage_q = zlp_q ? ST_DATA_IN : ST_LAST_IN;
      zlp_q = 1'b0;
      remain_q = '0;
    end
  endtask

  // Accept one OUT chunk; short packets stall, surplus bytes are dropped.
  task automatic take_chunk(input logic [9:0] count, output bit took);
    int unsigned mps;
    int unsigned want;
    mps = packet_bytes();
    want = (remain_q < mps) ? {16'd0, remain_q} : mps;
    took = 1'b0;
    if (count < want) begin
      stall_transfer();
    end else begin
      nx.act = ACT_ACCEPT;
      nx.offset = offset_q;
      nx.len = want[6:0];
      offset_q = offset_q + want[15:0];
      remain_q = remain_q - want[15:0];
      took = 1'b1;
    end
  endtask

  task automatic start_setup(input in_beat_t ev);
    int unsigned mps;
    int unsigned len;
    mps = packet_bytes();
    armed_q = 1'b0;
    if (!ev.setup_ok) begin
      stall_transfer();
      return;
    end
    saved_type_q = ev.request_type;
    saved_code_q = ev.request_code;
    saved_value_q = ev.request_value;
    saved_length_q = ev.request_length;
    if (saved_length_q == 16'd0 || saved_type_q[DIR_BIT]) begin
      len = {16'd0, ev.reply_length};
      offset_q = '0;
      if (!ev.handled) begin
        stall_transfer();
        return;
      end
      if (len > TRANSFER_SIZE) len = TRANSFER_SIZE;
      if (len > saved_length_q) len = {16'd0, saved_length_q};
      armed_q = ev.wants_completion;
      if (saved_length_q != 16'd0) begin
        zlp_q = (len < saved_length_q) && (len != 0) && ((len & (mps - 1)) == 0);
        remain_q = len[15:0];
        send_chunk();
      end else begin
        remain_q = '0;
        nx.act = ACT_SEND;
        nx.offset = '0;
        nx.len = '0;
        stage_q = ST_STATUS_IN;
      end
    end else if (saved_length_q > TRANSFER_SIZE) begin
      stall_transfer();
    end else begin
      offset_q = '0;
      remain_q = saved_length_q;
      stage_q = (saved_length_q > mps) ? ST_DATA_OUT : ST_LAST_OUT;
    end
  endtask

  task automatic take_out(input in_beat_t ev);
    bit took;
    case (stage_q)
      ST_DATA_OUT: begin
        take_chunk(ev.out_count, took);
        if (took && remain_q <= packet_bytes()) stage_q = ST_LAST_OUT;
      end
      ST_LAST_OUT: begin
        take_chunk(ev.out_count, took);
        if (took) begin
          if (ev.handled) begin
            armed_q = ev.wants_completion;
            stage_q = ST_STATUS_IN;
          end else begin
            stall_transfer();
          end
        end
      end
      ST_STATUS_OUT: begin
        nx.act = ACT_ACCEPT;
        stage_q = ST_IDLE;
        nx.pulse = armed_q;
        armed_q = 1'b0;
      end
      default: stall_transfer();
    endcase
  endtask

  task automatic take_in_done();
    case (stage_q)
      ST_DATA_IN: send_chunk();
      ST_LAST_IN: stage_q = ST_STATUS_OUT;
      ST_STATUS_IN: begin
        nx.pulse = armed_q;
        armed_q = 1'b0;
        // new address only lands once the status stage is acknowledged
        if (saved_type_q == REQ_TYPE_STD_DEV_OUT && saved_code_q == REQ_SET_ADDRESS)
          address_q = saved_value_q[6:0];
        stage_q = ST_IDLE;
      end
      default: stall_transfer();
    endcase
  endtask

  task automatic step_endpoint(input in_beat_t ev);
    nx = '0;
    case (cmd_t'(ev.cmd))
      CMD_BUS_RESET: clear_transfer();
      CMD_SETUP:     start_setup(ev);
      CMD_OUT:       take_out(ev);
      default:       take_in_done();
    endcase
    nx.stg = stage_q;
    nx.addr = address_q;
    expected_actions.push_back(nx);
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  task automatic compare_result();
    ep0_result_t want;
    if (expected_actions.size() == 0) begin
      report_mismatch("unexpected result beat, action", {14'd0, action}, 16'd0);
      return;
    end
    want = expected_actions.pop_front();
    if (action !== want.act)
      report_mismatch("action", {14'd0, action}, {14'd0, want.act});
    if (data_offset !== want.offset) report_mismatch("data_offset", data_offset, want.offset);
    if (data_length !== want.len)
      report_mismatch("data_length", {9'd0, data_length}, {9'd0, want.len});
    if (stage !== want.stg) report_mismatch("stage", {13'd0, stage}, {13'd0, want.stg});
    if (device_address !== want.addr)
      report_mismatch("device_address", {9'd0, device_address}, {9'd0, want.addr});
    if (complete_pulse !== want.pulse)
      report_mismatch("complete_pulse", {15'd0, complete_pulse}, {15'd0, want.pulse});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mps_log2 = MPS_LOG2_RESET;
      clear_transfer();
      expected_actions.delete();
    end else begin
      if (cfg_write_en) mps_log2 = cfg_write_data;
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) step_endpoint(seen_beat);
    end
    outstanding <= expected_actions.size();
  end

endmodule

### sim/tb.sv
// Testbench top for the endpoint-zero sequencer: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb;
  import uctl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [7:0]  request_type = '0;
  logic [7:0]  request_code = '0;
  logic [15:0] request_value = '0;
  logic [15:0] request_length = '0;
  logic        setup_ok = 1'b0;
  logic        handled = 1'b0;
  logic [15:0] reply_length = '0;
  logic        wants_completion = 1'b0;
  logic [9:0]  out_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  action;
  logic [15:0] data_offset;
  logic [6:0]  data_length;
  logic [2:0]  stage;
  logic [6:0]  device_address;
  logic        complete_pulse;

  int fail_count;
  int outstanding;

  // Flow-control knobs, in percent per cycle; changed at phase boundaries.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Bump to ask the result side for one long hold-off.
  int hold_asks = 0;
  // Packet size the stimulus plans transfers around; tracks the register.
  int mps = 64;
  int items_sent = 0;
  in_beat_t transfer_plan[$];

  usb_control_transfer_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .request_type(request_type), .request_code(request_code),
    .request_value(request_value), .request_length(request_length),
    .setup_ok(setup_ok), .handled(handled), .reply_length(reply_length),
    .wants_completion(wants_completion), .out_count(out_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .data_offset(data_offset), .data_length(data_length),
    .stage(stage), .device_address(device_address), .complete_pulse(complete_pulse)
  );

  ep0_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .request_type(request_type), .request_code(request_code),
    .request_value(request_value), .request_length(request_length),
    .setup_ok(setup_ok), .handled(handled), .reply_length(reply_length),
    .wants_completion(wants_completion), .out_count(out_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .data_offset(data_offset), .data_length(data_length),
    .stage(stage), .device_address(device_address), .complete_pulse(complete_pulse),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Give up well past the slowest legal run.
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // Result side: random stalls per phase, plus a long hold-off on request.
  initial begin : result_side
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
      end
    end
  end

  // Fill every field at random, then force the event code.
  function automatic in_beat_t random_beat(input cmd_t c);
    in_beat_t b;
    b.cmd = c;
    b.request_type = 8'($urandom_range(255));
    b.request_code = 8'($urandom_range(255));
    b.request_value = 16'($urandom_range(65535));
    b.request_length = 16'($urandom_range(65535));
    b.setup_ok = 1'($urandom_range(1));
    b.handled = 1'($urandom_range(1));
    b.reply_length = 16'($urandom_range(65535));
    b.wants_completion = 1'($urandom_range(1));
    b.out_count = 10'($urandom_range(1023));
    return b;
  endfunction

  // Mostly up to three packets long, sometimes just past the buffer, rarely anything.
  function automatic logic [15:0] pick_length(input int lo);
    int p;
    p = $urandom_range(99);
    if (p < 65) return 16'($urandom_range(3 * mps, lo));
    if (p < 90) return 16'($urandom_range(1100, lo));
    return 16'($urandom_range(65535, lo));
  endfunction

  // Bias replies toward whole packets so the zero-length tail shows up.
  function automatic logic [15:0] pick_reply(input logic [15:0] wlen);
    int p;
    p = $urandom_range(99);
    if (p < 30) return 16'(int'($urandom_range(4)) * mps);
    if (p < 60) return 16'($urandom_range(int'(wlen)));
    if (p < 85) return 16'($urandom_range(1100));
    return 16'($urandom_range(65535));
  endfunction

  // Device-to-host transfer: setup, one IN ack per data packet, then status OUT.
  task automatic plan_read(input logic [15:0] wlen, input logic [15:0] rlen,
                           input logic ok, input logic hand);
    in_beat_t b;
    int n;
    int pkts;
    b = random_beat(CMD_SETUP);
    b.request_type[DIR_BIT] = 1'b1;
    b.request_length = wlen;
    b.setup_ok = ok;
    b.handled = hand;
    b.reply_length = rlen;
    transfer_plan.push_back(b);
    if (!ok || !hand) return;
    if (wlen == 16'd0) begin
      transfer_plan.push_back(random_beat(CMD_IN_DONE));
      return;
    end
    n = int'(rlen);
    if (n > TRANSFER_SIZE) n = TRANSFER_SIZE;
    if (n > int'(wlen)) n = int'(wlen);
    pkts = (n + mps - 1) / mps;
    if (pkts == 0) pkts = 1;
    // short reply that ends on a packet boundary needs an empty packet
    if (n < int'(wlen) && n != 0 && n % mps == 0) pkts++;
    repeat (pkts) transfer_plan.push_back(random_beat(CMD_IN_DONE));
    transfer_plan.push_back(random_beat(CMD_OUT));
  endtask

  // Host-to-device transfer: setup, OUT chunks, then status IN if accepted.
  // short_at picks an OUT packet to cut short; -1 keeps all of them whole.
  task automatic plan_write(input logic [15:0] wlen, input logic hand, input int short_at);
    in_beat_t b;
    int rem;
    int want;
    int k;
    b = random_beat(CMD_SETUP);
    b.request_type[DIR_BIT] = 1'b0;
    b.request_length = wlen;
    b.setup_ok = 1'b1;
    transfer_plan.push_back(b);
    if (wlen == 16'd0 || wlen > TRANSFER_SIZE) return;
    rem = int'(wlen);
    k = 0;
    while (rem > 0) begin
      want = (rem < mps) ? rem : mps;
      b = random_beat(CMD_OUT);
      if (k == short_at) begin
        b.out_count = 10'(want - 1);
        transfer_plan.push_back(b);
        return;
      end
      if ($urandom_range(99) < 80) b.out_count = 10'(want + int'($urandom_range(3)));
      else b.out_count = 10'($urandom_range(1023, want));
      rem -= want;
      if (rem == 0) b.handled = hand;
      transfer_plan.push_back(b);
      k++;
    end
    if (hand) transfer_plan.push_back(random_beat(CMD_IN_DONE));
  endtask

  // No data stage: setup straight into status IN.
  task automatic plan_nodata(input logic [7:0] rtype, input logic [7:0] code,
                             input logic [15:0] value, input logic hand);
    in_beat_t b;
    b = random_beat(CMD_SETUP);
    b.request_type = rtype;
    b.request_code = code;
    b.request_value = value;
    b.request_length = '0;
    b.setup_ok = 1'b1;
    b.handled = hand;
    transfer_plan.push_back(b);
    if (hand) transfer_plan.push_back(random_beat(CMD_IN_DONE));
  endtask

  task automatic plan_random_transfer();
    int pick;
    int idx;
    logic [15:0] wlen;
    pick = $urandom_range(99);
    if (pick < 30 || pick >= 85) begin
      wlen = pick_length(0);
      if (pick < 30 || $urandom_range(1))
        plan_read(wlen, pick_reply(wlen), $urandom_range(99) < 95, $urandom_range(99) < 90);
      else
        plan_write(pick_length(1), $urandom_range(99) < 85, -1);
    end else if (pick < 55) begin
      plan_write(pick_length(1), $urandom_range(99) < 85,
                 ($urandom_range(99) < 8) ? int'($urandom_range(3)) : -1);
    end else if (pick < 70) begin
      plan_nodata($urandom_range(1) ? REQ_TYPE_STD_DEV_OUT : 8'($urandom_range(255)),
                  $urandom_range(1) ? REQ_SET_ADDRESS : 8'($urandom_range(255)),
                  16'($urandom_range(65535)), $urandom_range(99) < 90);
    end else begin
      transfer_plan.push_back(random_beat(cmd_t'($urandom_range(3))));
    end
    // Break the sequence: drop one beat or swap in a stray event.
    if (pick >= 85 && transfer_plan.size() > 1) begin
      idx = $urandom_range(transfer_plan.size() - 1);
      if ($urandom_range(1)) transfer_plan.delete(idx);
      else transfer_plan[idx] = random_beat(cmd_t'($urandom_range(3)));
    end
  endtask

  // Offer one event beat; hold it until taken, then idle at random.
  task automatic send_beat(input in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    {cmd, request_type, request_code, request_value, request_length,
     setup_ok, handled, reply_length, wants_completion, out_count} <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = 0;
    while (int'($urandom_range(99)) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic play_plan();
    while (transfer_plan.size() > 0) send_beat(transfer_plan.pop_front());
  endtask

  // Drop valid and wait for every predicted beat to come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic set_mps(input logic [2:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    mps = 1 << ((v < MPS_LOG2_MIN) ? MPS_LOG2_MIN : (v > MPS_LOG2_MAX) ? MPS_LOG2_MAX : v);
  endtask

  initial begin : stimulus
    logic [2:0] cfg_plan [8];
    int phase;
    int target;
    bit held;
    bit paused;
    // cover both clamped ends as well as every legal size
    cfg_plan = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd4, 3'd5, 3'd1, 3'd2};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at the reset packet size of 64 bytes.
    plan_nodata(REQ_TYPE_STD_DEV_OUT, REQ_SET_ADDRESS, 16'hFFFF, 1'b1); // address 127
    plan_read(16'd100, 16'hFFFF, 1'b1, 1'b1);   // reply cut to the requested length
    plan_read(16'd200, 16'd128, 1'b1, 1'b1);    // short reply on a boundary: empty tail
    plan_write(16'hFFFF, 1'b1, -1);             // write too big for the buffer
    plan_write(16'd70, 1'b1, -1);               // two OUT packets then status
    plan_read(16'd64, 16'd10, 1'b0, 1'b1);      // incomplete setup packet
    plan_read(16'd64, 16'd10, 1'b1, 1'b0);      // handler refuses
    plan_write(16'd10, 1'b1, 0);                // short OUT packet
    plan_write(16'd8, 1'b0, -1);                // last OUT refused
    play_plan();
    begin
      in_beat_t b;
      send_beat(random_beat(CMD_IN_DONE));      // IN with nothing in flight
      b = random_beat(CMD_OUT);
      b.out_count = 10'h3FF;
      send_beat(b);
      b.out_count = '0;
      send_beat(b);
      send_beat(random_beat(CMD_BUS_RESET));    // back to address 0
    end

    // Random phases: one packet size and one flow-control mix each.
    for (phase = 0; phase < 8; phase++) begin
      drain();
      set_mps(cfg_plan[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      target = items_sent + 66;
      held = 1'b0;
      paused = 1'b0;
      while (items_sent < target) begin
        // Back-pressure: result side holds off while events keep coming.
        if (phase % 4 == 0 && !held && items_sent >= target - 40) begin
          hold_asks++;
          held = 1'b1;
        end
        // Quiet the event side until the block has answered everything.
        if (phase == 4 && !paused && items_sent >= target - 20) begin
          drain();
          paused = 1'b1;
        end
        plan_random_transfer();
        // Cut the plan off once the phase has its share of beats.
        while (transfer_plan.size() > 0 && items_sent < target)
          send_beat(transfer_plan.pop_front());
        transfer_plan.delete();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
